// File: src/tcs_pkg.sv
// Shared types, constants and the sequencer control store for the temperature smoother.
`default_nettype none

package tcs_pkg;

    localparam int RAW_W            = 20;
    localparam int CAL_W            = 16;
    localparam int TEMP_W           = 15;
    localparam int CFG_IDX_W        = 2;
    localparam int WINDOW_DEPTH_DEF = 5;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
    localparam logic [CAL_W-1:0] GAIN_RESET = 16'd6554;

    localparam logic [CFG_IDX_W-1:0] REG_CALIB_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_LINEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_SQUARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN  = 2'd3;

    // shared multiplier operand widths
    localparam int MA_W = 32;
    localparam int MB_W = 31;
    localparam int MP_W = MA_W + MB_W;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_FIRST = 4'd1;
    localparam t_step STEP_LAST  = 4'd12;

    typedef enum logic [2:0] {
        A_NONE, A_D1, A_D2, A_SQ, A_U, A_QUO, A_DIFF
    } t_asel;

    typedef enum logic [2:0] {
        B_NONE, B_T2, B_D2, B_T3, B_RECIP, B_DEPTH, B_GAIN
    } t_bsel;

    typedef enum logic [3:0] {
        WB_NONE, WB_VAR1, WB_TEMP, WB_WIN, WB_QUO, WB_REM, WB_MEAN, WB_ACC, WB_OUT
    } t_wb;

    typedef enum logic [1:0] {
        J_NEXT, J_WAIT_IN, J_WAIT_OUT, J_RESTART
    } t_jmp;

    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        t_wb   wb;
        t_jmp  jmp;
    } t_uword;

    // Microprogram: the product of step k is consumed by step k+1.
    function automatic t_uword f_ucode(input t_step step);
        t_uword uw;
        case (step)
            4'd0:    uw = '{A_NONE, B_NONE,  WB_NONE, J_WAIT_IN};
            4'd1:    uw = '{A_D1,   B_T2,    WB_NONE, J_NEXT};
            4'd2:    uw = '{A_D2,   B_D2,    WB_VAR1, J_NEXT};
            4'd3:    uw = '{A_SQ,   B_T3,    WB_NONE, J_NEXT};
            4'd4:    uw = '{A_NONE, B_NONE,  WB_TEMP, J_NEXT};
            4'd5:    uw = '{A_NONE, B_NONE,  WB_WIN,  J_NEXT};
            4'd6:    uw = '{A_U,    B_RECIP, WB_NONE, J_NEXT};
            4'd7:    uw = '{A_QUO,  B_DEPTH, WB_QUO,  J_NEXT};
            4'd8:    uw = '{A_NONE, B_NONE,  WB_REM,  J_NEXT};
            4'd9:    uw = '{A_NONE, B_NONE,  WB_MEAN, J_NEXT};
            4'd10:   uw = '{A_DIFF, B_GAIN,  WB_NONE, J_NEXT};
            4'd11:   uw = '{A_NONE, B_NONE,  WB_ACC,  J_NEXT};
            4'd12:   uw = '{A_NONE, B_NONE,  WB_OUT,  J_WAIT_OUT};
            default: uw = '{A_NONE, B_NONE,  WB_NONE, J_RESTART};
        endcase
        return uw;
    endfunction

    function automatic logic signed [TEMP_W-1:0] f_sat_temp(input logic signed [31:0] v);
        logic signed [TEMP_W-1:0] r;
        if (v < 32'(TEMP_MIN)) begin
            r = TEMP_MIN;
        end else if (v > 32'(TEMP_MAX)) begin
            r = TEMP_MAX;
        end else begin
            r = v[TEMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/tcs_in_if.sv
// Input channel: one raw sensor conversion per beat.
`default_nettype none

interface tcs_in_if import tcs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink   (input valid, input raw_reading, output ready);
endinterface

`default_nettype wire

// File: src/tcs_out_if.sv
// Output channel: compensated and smoothed temperature per beat.
`default_nettype none

interface tcs_out_if import tcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [TEMP_W-1:0] smoothed_centi;

    modport source (output valid, output temp_centi, output smoothed_centi, input ready);
    modport sink   (input valid, input temp_centi, input smoothed_centi, output ready);
endinterface

`default_nettype wire

// File: src/temp_compensate_smooth.sv
// Temperature compensation, moving-average window and low-pass filter, microcoded.
//
// Usage:
//   i_in  : one raw 20-bit conversion per beat (valid/ready).
//   o_out : one beat per reading: compensated temp_centi and smoothed_centi,
//           both in hundredths of a degree, saturated to -4000..8500.
//   cfg   : i_cfg_we/i_cfg_idx/i_cfg_wdata write calib_offset, calib_linear,
//           calib_square and smooth_gain (indexes 0..3); write only when idle.
// Sequencing: a taken reading runs the 12-step microprogram, which runs six
//   multiplies through a single shared multiplier; the next reading is taken
//   only after the last step, once the result has been loaded for output.
// Reset: calibration words clear, smooth_gain returns to 6554, the window,
//   its running sum and the filter state clear to zero.
// Stall: a finished result waits in the output register; the next reading is
//   taken and worked on meanwhile, and the sequencer holds at its last step
//   until the output register is free.
`default_nettype none

module temp_compensate_smooth import tcs_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CAL_W-1:0]     i_cfg_wdata,
    tcs_in_if.sink                    i_in,
    tcs_out_if.source                 o_out
);

    localparam int REM_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = TEMP_W + $clog2(WINDOW_DEPTH + 1);
    localparam int U_W    = SUM_W - 1 + $clog2(WINDOW_DEPTH + 1);
    localparam int K_SH   = U_W + 4;
    localparam int RECIP  = ((1 << K_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int FRAC_N = 2 ** REM_W;
    localparam int VAR_W  = 23;
    localparam int TS_W   = VAR_W + 1;
    localparam int T5_W   = 28;
    localparam int ACC_W  = 31;

    localparam logic [U_W-1:0]   BIAS     = U_W'(WINDOW_DEPTH * (1 << (SUM_W - 1)));
    localparam logic [U_W-1:0]   QBIAS    = U_W'(1 << (SUM_W - 1));
    localparam logic [REM_W-1:0] LAST_POS = REM_W'(WINDOW_DEPTH - 1);

    // calibration registers
    logic [CAL_W-1:0]        r_calib_offset;
    logic signed [CAL_W-1:0] r_calib_linear;
    logic signed [CAL_W-1:0] r_calib_square;
    logic [CAL_W-1:0]        r_smooth_gain;

    // sequencer
    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   in_acc;
    logic   out_free;
    logic   wb_en;

    // datapath
    logic [RAW_W-1:0]         r_raw;
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [MP_W-1:0]   r_prod;
    logic signed [VAR_W-1:0]  r_var1;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [TEMP_W-1:0] r_win [WINDOW_DEPTH];
    logic [REM_W-1:0]         r_wpos;
    logic signed [SUM_W-1:0]  r_sum;
    logic [U_W-1:0]           r_quo;
    logic [REM_W-1:0]         r_rem;
    logic signed [ACC_W-1:0]  r_mean;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic signed [TEMP_W-1:0] r_out_smooth;

    logic signed [17:0]       w_d1;
    logic signed [16:0]       w_d2;
    logic [U_W-1:0]           w_u;
    logic [U_W-1:0]           w_rem_full;
    logic [U_W-1:0]           w_qs;
    logic signed [MA_W-1:0]   w_diff;
    logic signed [VAR_W-1:0]  w_var2;
    logic signed [TS_W-1:0]   w_tsum;
    logic signed [T5_W-1:0]   w_tx;
    logic signed [T5_W-1:0]   w_t5;
    logic signed [T5_W-1:0]   w_tshift;
    logic signed [31:0]       w_smr;
    logic signed [31:0]       w_sm;
    logic [15:0]              w_frac [FRAC_N];

    // floor(r * 65536 / depth) for each remainder
    for (genvar g = 0; g < FRAC_N; g++) begin : g_frac
        localparam logic [15:0] FV = 16'((g * 65536) / WINDOW_DEPTH);
        assign w_frac[g] = FV;
    end

    assign uw       = f_ucode(r_step);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign wb_en    = (uw.jmp != J_WAIT_OUT) || out_free;

    assign i_in.ready           = (uw.jmp == J_WAIT_IN);
    assign o_out.valid          = r_out_valid;
    assign o_out.temp_centi     = r_out_temp;
    assign o_out.smoothed_centi = r_out_smooth;

    assign w_d1       = $signed({1'b0, r_raw[RAW_W-1:3]}) - $signed({1'b0, r_calib_offset, 1'b0});
    assign w_d2       = $signed({1'b0, r_raw[RAW_W-1:4]}) - $signed({1'b0, r_calib_offset});
    assign w_u        = U_W'(r_sum) + BIAS;
    assign w_rem_full = w_u - r_prod[U_W-1:0];
    assign w_qs       = r_quo - QBIAS;
    assign w_diff     = MA_W'(r_mean) - MA_W'(r_acc);

    assign w_var2   = $signed(r_prod[36:14]);
    assign w_tsum   = TS_W'(r_var1) + TS_W'(w_var2);
    assign w_tx     = T5_W'(w_tsum);
    assign w_t5     = (w_tx <<< 2) + w_tx + T5_W'(128);
    assign w_tshift = w_t5 >>> 8;

    assign w_smr = 32'(r_acc) + 32'sd32768;
    assign w_sm  = w_smr >>> 16;

    always_comb begin
        case (uw.a_sel)
            A_D1:    w_ma = MA_W'(w_d1);
            A_D2:    w_ma = MA_W'(w_d2);
            A_SQ:    w_ma = MA_W'(r_prod[31:12]);
            A_U:     w_ma = MA_W'(w_u);
            A_QUO:   w_ma = MA_W'(r_prod[K_SH+U_W-1:K_SH]);
            A_DIFF:  w_ma = w_diff;
            default: w_ma = '0;
        endcase
        case (uw.b_sel)
            B_T2:    w_mb = MB_W'(r_calib_linear);
            B_D2:    w_mb = MB_W'(w_d2);
            B_T3:    w_mb = MB_W'(r_calib_square);
            B_RECIP: w_mb = MB_W'(RECIP);
            B_DEPTH: w_mb = MB_W'(WINDOW_DEPTH);
            B_GAIN:  w_mb = MB_W'(r_smooth_gain);
            default: w_mb = '0;
        endcase
    end

    always_comb begin
        case (uw.jmp)
            J_NEXT:     n_step = r_step + t_step'(1);
            J_WAIT_IN:  n_step = in_acc ? STEP_FIRST : r_step;
            J_WAIT_OUT: n_step = out_free ? '0 : r_step;
            default:    n_step = '0;
        endcase
    end

    // control state, configuration, window and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_calib_offset <= '0;
            r_calib_linear <= '0;
            r_calib_square <= '0;
            r_smooth_gain  <= GAIN_RESET;
            r_wpos         <= '0;
            r_sum          <= '0;
            r_acc          <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CALIB_OFFSET: r_calib_offset <= i_cfg_wdata;
                    REG_CALIB_LINEAR: r_calib_linear <= $signed(i_cfg_wdata);
                    REG_CALIB_SQUARE: r_calib_square <= $signed(i_cfg_wdata);
                    REG_SMOOTH_GAIN:  r_smooth_gain  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_out.ready && !(wb_en && (uw.wb == WB_OUT))) begin
                r_out_valid <= 1'b0;
            end
            if (wb_en) begin
                case (uw.wb)
                    WB_WIN: begin
                        r_sum         <= r_sum - SUM_W'(r_win[r_wpos]) + SUM_W'(r_temp);
                        r_win[r_wpos] <= r_temp;
                        r_wpos        <= (r_wpos == LAST_POS) ? '0 : r_wpos + REM_W'(1);
                    end
                    WB_ACC: r_acc <= r_acc + $signed(r_prod[ACC_W+15:16]);
                    WB_OUT: r_out_valid <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (in_acc) begin
            r_raw <= i_in.raw_reading;
        end
        if (wb_en) begin
            case (uw.wb)
                WB_VAR1: r_var1 <= $signed(r_prod[33:11]);
                WB_TEMP: r_temp <= f_sat_temp(32'(w_tshift));
                WB_QUO:  r_quo  <= r_prod[K_SH+U_W-1:K_SH];
                WB_REM:  r_rem  <= w_rem_full[REM_W-1:0];
                WB_MEAN: r_mean <= $signed({w_qs[TEMP_W-1:0], w_frac[r_rem]});
                WB_OUT: begin
                    r_out_temp   <= r_temp;
                    r_out_smooth <= f_sat_temp(w_sm);
                end
                default: ;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_step == STEP_FIRST))
        else $error("accepted beat did not start the microprogram");

    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= LAST_POS)
        else $error("window write position out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.wb == WB_MEAN) |-> (r_rem <= LAST_POS))
        else $error("division remainder not below window depth");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_step) == STEP_LAST))
        else $error("result loaded outside the final step");

endmodule

`default_nettype wire

// File: sim/tb_temp_compensate_smooth.sv
// Self-checking testbench for temp_compensate_smooth: directed table, then random readings.
`default_nettype none

module tb_temp_compensate_smooth;
    timeunit 1ns;
    timeprecision 1ps;

    import tcs_pkg::*;

    localparam int DEPTH         = WINDOW_DEPTH_DEF;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 135;
    localparam int HOLD_PHASE    = 2;
    localparam int QUIET_PHASE   = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_WAIT      = 5000;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic signed [TEMP_W-1:0] smoothed_centi;
    } t_centi_pair;

    // values readable straight off the spec for a directed row
    typedef struct packed {
        logic                     has_temp;
        logic signed [TEMP_W-1:0] temp;
        logic                     has_smooth;
        logic signed [TEMP_W-1:0] smooth;
    } t_known;

    typedef struct {
        bit               is_setting;
        logic [RAW_W-1:0] raw;
        t_known           known;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] linear;
        logic [CAL_W-1:0] square;
        logic [CAL_W-1:0] gain;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CAL_W-1:0]     cfg_wdata;

    tcs_in_if  in_if ();
    tcs_out_if out_if ();

    temp_compensate_smooth #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // predictor state
    logic        [CAL_W-1:0]  m_offset;
    logic signed [CAL_W-1:0]  m_linear;
    logic signed [CAL_W-1:0]  m_square;
    logic        [CAL_W-1:0]  m_gain;
    logic signed [TEMP_W-1:0] m_window [DEPTH];
    int                       m_pos;
    longint                   m_sum;
    longint                   m_acc;

    t_centi_pair pending_temps [$];
    t_known      known_hints [$];
    t_dir_row    dir_rows [$];

    int mismatches      = 0;
    int readings_taken  = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int holds_done      = 0;
    bit hold_req        = 1'b0;
    bit quiet_phase     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp_centi(input longint v);
        if (v < longint'(TEMP_MIN)) return longint'(TEMP_MIN);
        if (v > longint'(TEMP_MAX)) return longint'(TEMP_MAX);
        return v;
    endfunction

    function automatic longint compensate(input logic [RAW_W-1:0] raw);
        longint c, t1, d1, d2, v1, v2;
        c  = longint'(raw);
        t1 = longint'(m_offset);
        d1 = (c >>> 3) - 2 * t1;
        v1 = (d1 * longint'(m_linear)) >>> 11;
        d2 = (c >>> 4) - t1;
        v2 = (((d2 * d2) >>> 12) * longint'(m_square)) >>> 14;
        return clamp_centi(((v1 + v2) * 5 + 128) >>> 8);
    endfunction

    task automatic step_smoother(input logic signed [TEMP_W-1:0] t,
                                 output logic signed [TEMP_W-1:0] sm);
        longint num, mean, diff, full;
        m_sum = m_sum - longint'(m_window[m_pos]) + longint'(t);
        m_window[m_pos] = t;
        m_pos = (m_pos + 1) % DEPTH;
        num  = m_sum * 65536;
        mean = (num >= 0) ? num / DEPTH : -((-num + DEPTH - 1) / DEPTH);
        diff = mean - m_acc;
        m_acc = m_acc + ((diff * longint'(m_gain)) >>> 16);
        full = clamp_centi((m_acc + 32768) >>> 16);
        sm = full[TEMP_W-1:0];
    endtask

    task automatic flag_error(input string what, input t_centi_pair want,
                              input t_centi_pair got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("ERROR %s: expected temp %0d smooth %0d, got temp %0d smooth %0d",
                     what, want.temp_centi, want.smoothed_centi,
                     got.temp_centi, got.smoothed_centi);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_centi_pair              want, got;
        t_known                   hint;
        logic signed [TEMP_W-1:0] t, sm;
        longint                   full;
        if (!i_rst_n) begin
            m_offset = '0;
            m_linear = '0;
            m_square = '0;
            m_gain   = GAIN_RESET;
            for (int i = 0; i < DEPTH; i++) m_window[i] = '0;
            m_pos = 0;
            m_sum = 0;
            m_acc = 0;
            pending_temps.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_CALIB_OFFSET: m_offset = cfg_wdata;
                    REG_CALIB_LINEAR: m_linear = cfg_wdata;
                    REG_CALIB_SQUARE: m_square = cfg_wdata;
                    REG_SMOOTH_GAIN:  m_gain   = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                readings_taken++;
                full = compensate(in_if.raw_reading);
                t = full[TEMP_W-1:0];
                step_smoother(t, sm);
                hint = (known_hints.size() != 0) ? known_hints.pop_front() : '0;
                want.temp_centi     = hint.has_temp   ? hint.temp   : t;
                want.smoothed_centi = hint.has_smooth ? hint.smooth : sm;
                pending_temps.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                got.temp_centi     = out_if.temp_centi;
                got.smoothed_centi = out_if.smoothed_centi;
                if (pending_temps.size() == 0) begin
                    flag_error("unexpected beat", '0, got);
                end else begin
                    want = pending_temps.pop_front();
                    results_checked++;
                    if (got.temp_centi !== want.temp_centi)
                        flag_error("temp_centi", want, got);
                    if (got.smoothed_centi !== want.smoothed_centi)
                        flag_error("smoothed_centi", want, got);
                end
            end
        end
    end

    // receiver: random back-pressure, always ready in the quiet phase, plus one long hold on request
    initial begin : result_sink
        int stall_left;
        int r;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (quiet_phase) begin
                out_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                r = int'($urandom_range(0, 99));
                if (r < 70) begin
                    out_if.ready <= 1'b1;
                end else if (r < 95) begin
                    out_if.ready <= 1'b0;
                    stall_left = int'($urandom_range(0, 3));
                end else begin
                    out_if.ready <= 1'b0;
                    stall_left = int'($urandom_range(10, 40));
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (quiet_phase) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw(input logic [CAL_W-1:0] off);
        int r, v;
        r = int'($urandom_range(0, 99));
        if (r < 45) begin
            // around the operating point of the current calibration
            v = int'(off) * 16 + int'($urandom_range(0, 131072)) - 65536;
            if (v < 0) v = 0;
            if (v > 1048575) v = 1048575;
        end else if (r < 85) begin
            v = int'($urandom_range(0, 1048575));
        end else if (r < 92) begin
            v = ($urandom_range(0, 1) != 0) ? 1048575 : 0;
        end else begin
            v = int'($urandom_range(0, 255));
        end
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [CAL_W-1:0] pick_word(input bit is_signed);
        case ($urandom_range(0, 3))
            0:       return is_signed ? 16'h8000 : 16'h0000;
            1:       return is_signed ? 16'h7FFF : 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic add_setting(input logic [CAL_W-1:0] o, input logic [CAL_W-1:0] l,
                               input logic [CAL_W-1:0] s, input logic [CAL_W-1:0] g);
        t_dir_row row;
        row.is_setting = 1'b1;
        row.raw        = '0;
        row.known      = '0;
        row.offset     = o;
        row.linear     = l;
        row.square     = s;
        row.gain       = g;
        dir_rows.push_back(row);
    endtask

    task automatic add_reading(input logic [RAW_W-1:0] raw,
                               input logic has_t, input logic signed [TEMP_W-1:0] t,
                               input logic has_s, input logic signed [TEMP_W-1:0] s);
        t_dir_row row;
        row.is_setting       = 1'b0;
        row.raw              = raw;
        row.known.has_temp   = has_t;
        row.known.temp       = t;
        row.known.has_smooth = has_s;
        row.known.smooth     = s;
        row.offset           = '0;
        row.linear           = '0;
        row.square           = '0;
        row.gain             = '0;
        dir_rows.push_back(row);
    endtask

    task automatic offer_reading(input logic [RAW_W-1:0] raw, input t_known hint);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_reading <= raw;
        known_hints.push_back(hint);
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_temps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CAL_W-1:0] o, input logic [CAL_W-1:0] l,
                                 input logic [CAL_W-1:0] s, input logic [CAL_W-1:0] g);
        write_reg(REG_CALIB_OFFSET, o);
        write_reg(REG_CALIB_LINEAR, l);
        write_reg(REG_CALIB_SQUARE, s);
        write_reg(REG_SMOOTH_GAIN, g);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [CAL_W-1:0] w_off, w_lin, w_sq, w_gain;
        int               waited;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_CALIB_OFFSET;
        cfg_wdata         <= '0;
        in_if.valid       <= 1'b0;
        in_if.raw_reading <= '0;

        // reset calibration: everything compensates to zero
        add_reading(20'h00000, 1'b1, 15'sd0, 1'b1, 15'sd0);
        add_reading(20'hFFFFF, 1'b1, 15'sd0, 1'b1, 15'sd0);
        add_reading(20'h5A5A5, 1'b1, 15'sd0, 1'b1, 15'sd0);
        // typical sensor calibration, gain near one, window filling
        add_setting(16'd27504, 16'd26435, -16'sd1000, 16'hFFFF);
        add_reading(20'd519888, 1'b0, '0, 1'b0, '0);
        add_reading(20'h00000, 1'b0, '0, 1'b0, '0);
        add_reading(20'hFFFFF, 1'b0, '0, 1'b0, '0);
        add_reading(20'h7FFFF, 1'b0, '0, 1'b0, '0);
        add_reading(20'd440000, 1'b0, '0, 1'b0, '0);
        add_reading(20'd450000, 1'b0, '0, 1'b0, '0);
        // high saturation, gain zero holds the filter
        add_setting(16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000);
        add_reading(20'hFFFFF, 1'b1, TEMP_MAX, 1'b0, '0);
        add_reading(20'h00000, 1'b1, 15'sd0, 1'b0, '0);
        add_reading(20'h12345, 1'b0, '0, 1'b0, '0);
        // low saturation, most negative calibration words
        add_setting(16'h0000, 16'h8000, 16'h8000, 16'hFFFF);
        add_reading(20'hFFFFF, 1'b1, TEMP_MIN, 1'b0, '0);
        add_reading(20'h80000, 1'b1, TEMP_MIN, 1'b0, '0);
        add_reading(20'hFFFFF, 1'b1, TEMP_MIN, 1'b0, '0);
        add_reading(20'h80000, 1'b1, TEMP_MIN, 1'b0, '0);
        add_reading(20'hFFFFF, 1'b1, TEMP_MIN, 1'b0, '0);
        // widest intermediates: largest offset
        add_setting(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000);
        add_reading(20'h00000, 1'b0, '0, 1'b0, '0);
        add_reading(20'hFFFFF, 1'b0, '0, 1'b0, '0);
        add_reading(20'h55555, 1'b0, '0, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_setting) begin
                wait_idle();
                apply_setting(dir_rows[k].offset, dir_rows[k].linear,
                              dir_rows[k].square, dir_rows[k].gain);
            end else begin
                offer_reading(dir_rows[k].raw, dir_rows[k].known);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            if ($urandom_range(0, 99) < 60) begin
                w_off  = 16'($urandom_range(26000, 29500));
                w_lin  = 16'($urandom_range(24000, 28000));
                w_sq   = 16'(int'($urandom_range(0, 8000)) - 4000);
                w_gain = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 8000))
                                                     : pick_word(1'b0);
            end else begin
                w_off  = pick_word(1'b0);
                w_lin  = pick_word(1'b1);
                w_sq   = pick_word(1'b1);
                w_gain = pick_word(1'b0);
            end
            apply_setting(w_off, w_lin, w_sq, w_gain);
            quiet_phase = (ph == QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == HOLD_PHASE && n == 30) hold_req = 1'b1;
                offer_reading(pick_raw(w_off), '0);
            end
        end

        in_if.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending_temps.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_temps.size() != 0) begin
            $display("ERROR %0d results never arrived", pending_temps.size());
            mismatches += pending_temps.size();
        end

        $display("Run covered %0d readings under %0d calibration settings, %0d beats checked,",
                 readings_taken, settings_used, results_checked);
        $display("%0d long output hold(s), %0d error(s).", holds_done, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/tcs_pkg.sv
src/tcs_in_if.sv
src/tcs_out_if.sv
src/temp_compensate_smooth.sv
sim/tb_temp_compensate_smooth.sv
